// ----- sv/psch_pkg.sv -----
// shared constants, types and codes of the priority scheduler
package psch_pkg;

   localparam int SLOTS           = 16;
   localparam int PRIORITY_BITS   = 8;
   localparam int BURST_BITS      = 16;
   localparam int ID_BITS         = 8;
   localparam int IN_PRIO_BITS    = 8;
   localparam int IN_BURST_BITS   = 16;
   localparam int TIME_BITS       = 32;
   localparam int SLOT_BITS       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TREE_LEVELS     = SLOT_BITS;
   localparam int TREE_LEAVES     = 1 << SLOT_BITS;
   localparam int SEARCH_CNT_BITS = $clog2(TREE_LEVELS + 1);
   localparam logic [SEARCH_CNT_BITS-1:0] SEARCH_LAST = SEARCH_CNT_BITS'(TREE_LEVELS);

   localparam logic KIND_ARRIVAL = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   typedef enum logic [1:0] {
      EV_ACCEPT = 2'd0,
      EV_DROP   = 2'd1,
      EV_TICK   = 2'd2,
      EV_FINISH = 2'd3
   } psch_event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_FINISH,
      ST_SEARCH,
      ST_ADVANCE,
      ST_RESPOND
   } psch_state_type;

   typedef struct packed {
      logic                     valid;
      logic                     run;
      logic [ID_BITS-1:0]       id;
      logic [PRIORITY_BITS-1:0] prio;
      logic [BURST_BITS-1:0]    remaining;
   } psch_entry_type;

   // broadcast to every cell of the table
   typedef struct packed {
      logic                 append;
      logic                 remove;
      logic                 select;
      logic [SLOT_BITS-1:0] select_slot;
      logic                 dec;
   } psch_cmd_type;

endpackage

// ----- sv/psch_req_if.sv -----
// request channel: task arrivals and ticks
interface psch_req_if
   import psch_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic [ID_BITS-1:0]       task_id;
   logic [IN_PRIO_BITS-1:0]  task_priority;
   logic [IN_BURST_BITS-1:0] burst_length;

   modport source (output valid, kind, task_id, task_priority, burst_length, input ready);
   modport sink   (input valid, kind, task_id, task_priority, burst_length, output ready);
endinterface

// ----- sv/psch_rsp_if.sv -----
// response channel: one result beat per request beat
interface psch_rsp_if
   import psch_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           event_res;
   logic [ID_BITS-1:0]   finished_id;
   logic [TIME_BITS-1:0] finish_time;
   logic                 busy_res;
   logic [ID_BITS-1:0]   running_id;
   logic                 table_empty;

   modport source (output valid, event_res, finished_id, finish_time, busy_res, running_id,
                   table_empty, input ready);
   modport sink   (input valid, event_res, finished_id, finish_time, busy_res, running_id,
                   table_empty, output ready);
endinterface

// ----- sv/psch_cell.sv -----
// one slot of the ready table, shifts down from its upper neighbor on removal
module psch_cell
   import psch_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  psch_cmd_type         cmd,
   input  logic [SLOT_BITS-1:0] slot_index,
   input  psch_entry_type       item,
   input  logic                 prev_valid,
   input  logic                 remove_in,
   output logic                 remove_out,
   input  psch_entry_type       next_entry,
   output psch_entry_type       entry
);

   psch_entry_type entry_ff;
   psch_entry_type entry_in;

   // removal ripples up from the finishing cell
   assign remove_out = remove_in | (entry_ff.valid & entry_ff.run & (entry_ff.remaining == '0));

   always_comb begin
      entry_in = entry_ff;
      if (cmd.remove && remove_out) begin
         entry_in = next_entry;
      end else if (cmd.append && !entry_ff.valid && prev_valid) begin
         entry_in = item;
      end else if (cmd.select) begin
         entry_in.run = entry_ff.valid && (cmd.select_slot == slot_index);
      end else if (cmd.dec && entry_ff.run && (entry_ff.remaining != '0)) begin
         entry_in.remaining = entry_ff.remaining - 1'b1;
      end
   end

   // only the flags are reset, the payload is don't-care while invalid
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         entry_ff.run   <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
         entry_ff.run   <= entry_in.run;
      end
      entry_ff.id        <= entry_in.id;
      entry_ff.prio      <= entry_in.prio;
      entry_ff.remaining <= entry_in.remaining;
   end

   assign entry = entry_ff;

endmodule

// ----- sv/psch_min_tree.sv -----
// registered compare tree: lowest priority value, lowest slot on a tie
module psch_min_tree
   import psch_pkg::*;
(
   input  logic                 clock,
   input  psch_entry_type       entries [SLOTS],
   output logic                 root_found,
   output logic [SLOT_BITS-1:0] root_slot
);

   typedef struct packed {
      logic                     empty;
      logic [PRIORITY_BITS-1:0] prio;
      logic [SLOT_BITS-1:0]     slot;
   } psch_node_type;

   function automatic psch_node_type pick(psch_node_type left, psch_node_type right);
      psch_node_type best;
      best = left;
      if (!right.empty && (left.empty || (right.prio < left.prio))) begin
         best = right;
      end
      return best;
   endfunction

   psch_node_type leaf    [TREE_LEAVES];
   psch_node_type node_ff [1:TREE_LEAVES-1];

   for (genvar g = 0; g < TREE_LEAVES; g++) begin : g_leaf
      if (g < SLOTS) begin : g_used
         assign leaf[g] = '{empty: !entries[g].valid, prio: entries[g].prio,
                            slot: SLOT_BITS'(g)};
      end else begin : g_pad
         assign leaf[g] = '{empty: 1'b1, prio: '0, slot: '0};
      end
   end

   for (genvar k = 1; k < TREE_LEAVES; k++) begin : g_node
      if (2 * k >= TREE_LEAVES) begin : g_bottom
         always_ff @(posedge clock) begin
            node_ff[k] <= pick(leaf[2*k-TREE_LEAVES], leaf[2*k+1-TREE_LEAVES]);
         end
      end else begin : g_inner
         always_ff @(posedge clock) begin
            node_ff[k] <= pick(node_ff[2*k], node_ff[2*k+1]);
         end
      end
   end

   assign root_found = !node_ff[1].empty;
   assign root_slot  = node_ff[1].slot;

endmodule

// ----- sv/nonpreemptive_priority_scheduler.sv -----
// Non-preemptive priority scheduler with a compacted ready table of cells.
//
// req_bus carries one beat per arrival (kind 0: id, priority, burst) or per
// tick (kind 1). rsp_bus returns exactly one beat per request beat, in order.
// The block works on one beat at a time: req_bus.ready is high only while
// the sequencer is idle.
// Steps per beat: an arrival passes ARRIVE and RESPOND; a tick while a task
// keeps running passes FINISH, ADVANCE and RESPOND; any other tick (finish,
// pick or empty table) passes FINISH, SEARCH, ADVANCE and RESPOND. SEARCH
// waits for the registered compare tree, which has one register per level.
// The response beat is registered; it appears in the same cycle as
// req_bus.ready rises again and is held until rsp_bus.ready. A stalled
// receiver leaves it in the output register; one more request beat can
// still be taken and worked, and its result then waits in the response
// state, so nothing further is taken until the register frees.
// Reset (synchronous) empties the table, clears the running task and the
// tick count, and drops any pending response beat.
module nonpreemptive_priority_scheduler_core
   import psch_pkg::*;
(
   input logic        clock,
   input logic        reset,
   psch_req_if.sink   req_bus,
   psch_rsp_if.source rsp_bus
);

   psch_state_type state_ff, state_in;

   logic                       kind_ff;
   psch_entry_type             item_ff;
   psch_event_type             event_ff, event_in;
   logic [ID_BITS-1:0]         fin_id_ff, fin_id_in;
   logic [TIME_BITS-1:0]       fin_time_ff, fin_time_in;
   logic [TIME_BITS-1:0]       tick_ff, tick_in;
   logic [SEARCH_CNT_BITS-1:0] search_cnt_ff, search_cnt_in;

   logic                       rsp_valid_ff;
   psch_event_type             rsp_event_ff;
   logic [ID_BITS-1:0]         rsp_fin_id_ff;
   logic [TIME_BITS-1:0]       rsp_fin_time_ff;
   logic                       rsp_busy_ff;
   logic [ID_BITS-1:0]         rsp_run_id_ff;
   logic                       rsp_empty_ff;

   psch_cmd_type   cmd;
   psch_entry_type entries [SLOTS];
   psch_entry_type uppers  [SLOTS];
   logic [SLOTS:0] remove_chain;
   logic           req_take, rsp_load;
   logic           fin_any, busy_any;
   logic [ID_BITS-1:0] fin_id_mux, run_id_mux;
   logic           root_found;
   logic [SLOT_BITS-1:0] root_slot;

   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_load = (state_ff == ST_RESPOND) && (!rsp_valid_ff || rsp_bus.ready);

   // ---------------- table cells ----------------
   assign remove_chain[0] = 1'b0;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      if (g == SLOTS - 1) begin : g_top
         assign uppers[g] = '0;
      end else begin : g_mid
         assign uppers[g] = entries[g+1];
      end

      psch_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .slot_index (SLOT_BITS'(g)),
         .item       (item_ff),
         .prev_valid ((g == 0) ? 1'b1 : entries[(g == 0) ? 0 : g-1].valid),
         .remove_in  (remove_chain[g]),
         .remove_out (remove_chain[g+1]),
         .next_entry (uppers[g]),
         .entry      (entries[g])
      );
   end

   psch_min_tree u_tree (
      .clock      (clock),
      .entries    (entries),
      .root_found (root_found),
      .root_slot  (root_slot)
   );

   // one-hot selects over the cells
   always_comb begin
      fin_any    = 1'b0;
      busy_any   = 1'b0;
      fin_id_mux = '0;
      run_id_mux = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (entries[i].valid && entries[i].run) begin
            busy_any   = 1'b1;
            run_id_mux = run_id_mux | entries[i].id;
            if (entries[i].remaining == '0) begin
               fin_any    = 1'b1;
               fin_id_mux = fin_id_mux | entries[i].id;
            end
         end
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_bus.kind == KIND_TICK) ? ST_FINISH : ST_ARRIVE;
            end
         end
         ST_ARRIVE:  state_in = ST_RESPOND;
         ST_FINISH:  state_in = (busy_any && !fin_any) ? ST_ADVANCE : ST_SEARCH;
         ST_SEARCH: begin
            if (search_cnt_ff == SEARCH_LAST) begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      event_in      = event_ff;
      fin_id_in     = fin_id_ff;
      fin_time_in   = fin_time_ff;
      tick_in       = tick_ff;
      search_cnt_in = search_cnt_ff;
      req_bus.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ST_ARRIVE: begin
            cmd.append  = !entries[SLOTS-1].valid;
            event_in    = entries[SLOTS-1].valid ? EV_DROP : EV_ACCEPT;
            fin_id_in   = '0;
            fin_time_in = '0;
         end
         ST_FINISH: begin
            cmd.remove    = fin_any;
            event_in      = fin_any ? EV_FINISH : EV_TICK;
            fin_id_in     = fin_id_mux;
            fin_time_in   = fin_any ? tick_ff : '0;
            search_cnt_in = '0;
         end
         ST_SEARCH: begin
            search_cnt_in   = search_cnt_ff + 1'b1;
            cmd.select      = (search_cnt_ff == SEARCH_LAST) && root_found;
            cmd.select_slot = root_slot;
         end
         ST_ADVANCE: begin
            cmd.dec = 1'b1;
            tick_in = tick_ff + 1'b1;
         end
         ST_RESPOND: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         search_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         search_cnt_ff <= search_cnt_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      event_ff    <= event_in;
      fin_id_ff   <= fin_id_in;
      fin_time_ff <= fin_time_in;
      if (req_take) begin
         kind_ff        <= req_bus.kind;
         item_ff.valid  <= 1'b1;
         item_ff.run    <= 1'b0;
         item_ff.id     <= req_bus.task_id;
         item_ff.prio   <= PRIORITY_BITS'(req_bus.task_priority);
         item_ff.remaining <= BURST_BITS'(req_bus.burst_length);
      end
      if (rsp_load) begin
         rsp_event_ff    <= event_ff;
         rsp_fin_id_ff   <= (kind_ff == KIND_TICK) ? fin_id_ff : '0;
         rsp_fin_time_ff <= fin_time_ff;
         rsp_busy_ff     <= busy_any;
         rsp_run_id_ff   <= run_id_mux;
         rsp_empty_ff    <= !entries[0].valid;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.event_res   = rsp_event_ff;
   assign rsp_bus.finished_id = rsp_fin_id_ff;
   assign rsp_bus.finish_time = rsp_fin_time_ff;
   assign rsp_bus.busy_res    = rsp_busy_ff;
   assign rsp_bus.running_id  = rsp_run_id_ff;
   assign rsp_bus.table_empty = rsp_empty_ff;

endmodule

// ----- sv/psch_checker.sv -----
// port checks for the scheduler core and their binding
module psch_checker
   import psch_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [1:0]           event_res,
   input logic [ID_BITS-1:0]   finished_id,
   input logic [TIME_BITS-1:0] finish_time,
   input logic                 busy_res,
   input logic [ID_BITS-1:0]   running_id,
   input logic                 table_empty
);

   // a waiting result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_res) && $stable(running_id))
      else $error("response beat changed while stalled");

   // one beat in flight: no acceptance right after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken twice in a row");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_res == EV_ACCEPT || event_res == EV_DROP || event_res == EV_TICK)
      |-> finished_id == '0 && finish_time == '0)
      else $error("finish fields set without a finish");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !busy_res |-> running_id == '0)
      else $error("running id shown while idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && table_empty |-> !busy_res)
      else $error("busy with an empty table");

endmodule

bind nonpreemptive_priority_scheduler_core psch_checker u_psch_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .event_res   (rsp_bus.event_res),
   .finished_id (rsp_bus.finished_id),
   .finish_time (rsp_bus.finish_time),
   .busy_res    (rsp_bus.busy_res),
   .running_id  (rsp_bus.running_id),
   .table_empty (rsp_bus.table_empty)
);

// ----- test/psch_sched_checker.sv -----
// scoreboard for the priority scheduler: predicts each result beat and compares it
module psch_sched_checker
   import psch_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   psch_req_if        req_bus,
   psch_rsp_if        rsp_bus,
   output int         fail_count,
   output int         backlog
);

   typedef struct packed {
      psch_event_type       ev;
      logic [ID_BITS-1:0]   fin_id;
      logic [TIME_BITS-1:0] fin_time;
      logic                 busy;
      logic [ID_BITS-1:0]   run_id;
      logic                 empty;
   } sched_outcome_type;

   // shadow of the ready table, kept compacted in arrival order
   logic [ID_BITS-1:0]       ready_id   [SLOTS];
   logic [PRIORITY_BITS-1:0] ready_prio [SLOTS];
   logic [BURST_BITS-1:0]    ready_left [SLOTS];
   int                       table_count;
   logic                     run_active;
   int                       run_slot;
   logic [TIME_BITS-1:0]     tick_now;

   sched_outcome_type outcome_queue[$];
   int                errors;

   function automatic sched_outcome_type schedule_beat(input logic kind,
         input logic [ID_BITS-1:0] id, input logic [IN_PRIO_BITS-1:0] prio,
         input logic [IN_BURST_BITS-1:0] burst);
      sched_outcome_type res;
      int                i;
      int                best;
      res = '0;
      if (kind == KIND_ARRIVAL) begin
         if (table_count >= SLOTS) begin
            res.ev = EV_DROP;
         end else begin
            ready_id[table_count]   = id;
            ready_prio[table_count] = PRIORITY_BITS'(prio);
            ready_left[table_count] = BURST_BITS'(burst);
            table_count++;
            res.ev = EV_ACCEPT;
         end
      end else begin
         res.ev = EV_TICK;
         if (run_active && ready_left[run_slot] == '0) begin
            res.ev       = EV_FINISH;
            res.fin_id   = ready_id[run_slot];
            res.fin_time = tick_now;
            for (i = run_slot; i < table_count - 1; i++) begin
               ready_id[i]   = ready_id[i+1];
               ready_prio[i] = ready_prio[i+1];
               ready_left[i] = ready_left[i+1];
            end
            table_count--;
            run_active = 1'b0;
            run_slot   = 0;
         end
         // lowest value wins, strict compare keeps the earliest arrival on a tie
         if (!run_active && table_count > 0) begin
            best = 0;
            for (i = 1; i < table_count; i++) begin
               if (ready_prio[i] < ready_prio[best]) best = i;
            end
            run_active = 1'b1;
            run_slot   = best;
         end
         if (run_active && ready_left[run_slot] != '0) ready_left[run_slot]--;
         tick_now++;
      end
      res.busy   = run_active;
      res.run_id = run_active ? ready_id[run_slot] : '0;
      res.empty  = (table_count == 0);
      return res;
   endfunction

   always @(posedge clock) begin : watch
      sched_outcome_type want;
      sched_outcome_type got;
      if (reset) begin
         table_count = 0;
         run_active  = 1'b0;
         run_slot    = 0;
         tick_now    = '0;
         errors      = 0;
         outcome_queue.delete();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            outcome_queue.push_back(schedule_beat(req_bus.kind, req_bus.task_id,
                                                  req_bus.task_priority,
                                                  req_bus.burst_length));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.ev       = psch_event_type'(rsp_bus.event_res);
            got.fin_id   = rsp_bus.finished_id;
            got.fin_time = rsp_bus.finish_time;
            got.busy     = rsp_bus.busy_res;
            got.run_id   = rsp_bus.running_id;
            got.empty    = rsp_bus.table_empty;
            if (outcome_queue.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result beat with nothing outstanding: ev=%0d id=%0d",
                           $time, got.ev, got.fin_id);
            end else begin
               want = outcome_queue.pop_front();
               if (got.ev !== want.ev || got.fin_id !== want.fin_id ||
                   got.fin_time !== want.fin_time || got.busy !== want.busy ||
                   got.run_id !== want.run_id || got.empty !== want.empty) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: expected ev=%0d fin=%0d t=%0d busy=%0d run=%0d empty=%0d",
                              $time, want.ev, want.fin_id, want.fin_time, want.busy,
                              want.run_id, want.empty);
                     $display("%0t: actual   ev=%0d fin=%0d t=%0d busy=%0d run=%0d empty=%0d",
                              $time, got.ev, got.fin_id, got.fin_time, got.busy,
                              got.run_id, got.empty);
                  end
               end
            end
         end
      end
      fail_count <= errors;
      backlog    <= outcome_queue.size();
   end

endmodule

// ----- test/tb_nonpreemptive_priority_scheduler_core.sv -----
// top of the priority scheduler testbench: clock, reset, traffic and verdict
module tb_nonpreemptive_priority_scheduler_core;
   import psch_pkg::*;

   localparam int RANDOM_BEATS = 530;
   localparam int LONG_HOLD    = 120;
   localparam int RUN_LIMIT    = 800_000;

   logic clock;
   logic reset;
   int   fail_count;
   int   backlog;
   bit   calm_tail;
   bit   hold_off_req;

   psch_req_if req_bus ();
   psch_rsp_if rsp_bus ();

   nonpreemptive_priority_scheduler_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   psch_sched_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT * 4);
      $display("== FAIL ==");
      $finish;
   end

   // offers one beat, with an occasional idle burst first, and waits for it to be taken
   task automatic send_beat(input logic kind, input logic [ID_BITS-1:0] id,
         input logic [IN_PRIO_BITS-1:0] prio, input logic [IN_BURST_BITS-1:0] burst);
      int gap;
      if (!calm_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.kind          <= kind;
      req_bus.task_id       <= id;
      req_bus.task_priority <= prio;
      req_bus.burst_length  <= burst;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_tick();
      send_beat(KIND_TICK, ID_BITS'($urandom), IN_PRIO_BITS'($urandom),
                IN_BURST_BITS'($urandom));
   endtask

   // receiver: stall bursts, long ready stretches, and one long hold-off on request
   initial begin : receiver
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int i;
      int arrive_pct;
      int mode_left;
      int pick;
      logic [IN_PRIO_BITS-1:0]  prio;
      logic [IN_BURST_BITS-1:0] burst;

      calm_tail    = 1'b0;
      hold_off_req = 1'b0;
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.kind          <= KIND_ARRIVAL;
      req_bus.task_id       <= '0;
      req_bus.task_priority <= '0;
      req_bus.burst_length  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tick on an empty table, then a zero-burst task that finishes one tick after pick
      send_tick();
      send_beat(KIND_ARRIVAL, 8'h00, 8'h00, 16'h0000);
      send_tick();
      send_tick();
      // fill the table; four tasks tie on the lowest priority
      for (i = 0; i < SLOTS; i++) begin
         send_beat(KIND_ARRIVAL, (i == SLOTS - 1) ? 8'hFF : ID_BITS'(i * 17 + 3),
                   (i == SLOTS - 1) ? 8'hFF : ((i % 4 == 1) ? 8'd7 : IN_PRIO_BITS'(200 - i * 10)),
                   IN_BURST_BITS'(1 + i % 3));
      end
      // full table drops the arrival
      send_beat(KIND_ARRIVAL, 8'hAA, 8'h55, 16'hFFFF);
      send_tick();
      send_tick();
      send_tick();

      mode_left  = 0;
      arrive_pct = 50;
      for (i = 0; i < RANDOM_BEATS; i++) begin
         if (mode_left == 0) begin
            case ($urandom_range(0, 2))
               0: arrive_pct = 25;
               1: arrive_pct = 50;
               default: arrive_pct = 80;
            endcase
            mode_left = $urandom_range(8, 40);
         end
         mode_left--;
         if (i == 120) hold_off_req = 1'b1;
         if (i == RANDOM_BEATS - 50) calm_tail = 1'b1;
         if (i == RANDOM_BEATS - 12) begin
            // a long job late in the run counts down from the top of the burst range
            send_beat(KIND_ARRIVAL, 8'hC3, 8'hFF, 16'hFFFF);
         end else if ($urandom_range(1, 100) <= arrive_pct) begin
            prio = ($urandom_range(0, 1) == 0) ? IN_PRIO_BITS'($urandom_range(0, 255))
                                               : IN_PRIO_BITS'($urandom_range(0, 3));
            pick = $urandom_range(0, 19);
            if (pick == 0)       burst = '0;
            else if (pick < 15)  burst = IN_BURST_BITS'($urandom_range(1, 6));
            else                 burst = IN_BURST_BITS'($urandom_range(7, 60));
            send_beat(KIND_ARRIVAL, ID_BITS'($urandom_range(0, 255)), prio, burst);
         end else begin
            send_tick();
         end
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/psch_pkg.sv
sv/psch_req_if.sv
sv/psch_rsp_if.sv
sv/psch_cell.sv
sv/psch_min_tree.sv
sv/nonpreemptive_priority_scheduler.sv
sv/psch_checker.sv
test/psch_sched_checker.sv
test/tb_nonpreemptive_priority_scheduler_core.sv
